// ----- hdl/obt_pkg.sv -----
`default_nettype none
package obt_pkg;

	localparam int SLOTS  = 1024;
	localparam int ADDR_W = $clog2(SLOTS);
	localparam int CNT_W  = ADDR_W + 1;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_CANCEL = 3'd1;
	localparam logic [2:0] OP_MODIFY = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;

	localparam logic [1:0] SIDE_BUY  = 2'd0;
	localparam logic [1:0] SIDE_SELL = 2'd1;
	localparam logic [1:0] SIDE_NONE = 2'd2;
	localparam logic [1:0] SIDE_BAD  = 2'd3;

	localparam logic [1:0] ST_ORDER = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [41:0] SIZE_MAX  = '1;
	localparam logic [10:0] COUNT_MAX = '1;

	typedef struct packed {
		logic               valid;
		logic [31:0]        instrument;
		logic [63:0]        order_key;
		logic [1:0]         side;
		logic signed [63:0] price;
		logic [31:0]        size;
		logic [63:0]        stamp;
	} entry_t;

	typedef struct packed {
		logic signed [63:0] price;
		logic [41:0]        size;
		logic [10:0]        count;
	} level_t;

	function automatic level_t level_fold(level_t cur, logic signed [63:0] price,
		logic [31:0] size, logic buy);
		level_t     nxt;
		logic       better;
		logic [42:0] sum;
		nxt    = cur;
		better = buy ? (price > cur.price) : (price < cur.price);
		sum    = {1'b0, cur.size} + 43'(size);
		if (cur.count == '0 || better) begin
			nxt.price = price;
			nxt.size  = 42'(size);
			nxt.count = 11'd1;
		end else if (price == cur.price) begin
			nxt.size  = sum[42] ? SIZE_MAX : sum[41:0];
			nxt.count = (cur.count == COUNT_MAX) ? cur.count : cur.count + 11'd1;
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/obt_ram.sv -----
`default_nettype none
module obt_ram
	import obt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire entry_t            wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output entry_t                 rdata
);

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/order_book_with_top_of_book.sv -----
// channel | dir | tdata (low bit up)                                   | tuser
// s       | in  | instrument, order_key, order_side, limit_price,       | operation
//         |     | quantity, event_time, 6 zero bits                     |
// m       | out | rest_side, rest_price, rest_size, rest_time, bid_*,   | status
//         |     | ask_* (price, size, count), 4 zero bits               |
// Each message makes one pass over the slot memory, one read per cycle.
// After reset every slot of the memory is swept with s_tready low.
// A finished result waits in the output register; the next message is taken meanwhile,
// and the scan end holds until the output register is free.
`default_nettype none
module order_book_with_top_of_book
	import obt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [263:0] s_tdata,  // instrument, order_key, order_side, limit_price, quantity, event_time
	input  wire logic [2:0]   s_tuser,  // operation
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [399:0]      m_tdata,  // rest_side, rest_price, rest_size, rest_time, bid p/s/c, ask p/s/c
	output logic [1:0]        m_tuser   // status
);

	typedef enum logic [3:0] {
		S_WIPE  = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_APPLY = 4'b1000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [2:0]         op_q;
	logic [31:0]        inst_q;
	logic [63:0]        key_q;
	logic [1:0]         side_q;
	logic signed [63:0] price_q;
	logic [31:0]        qty_q;
	logic [63:0]        time_q;

	logic              hit_q, free_q;
	logic [ADDR_W-1:0] hit_idx_q, free_idx_q;
	entry_t            hit_e_q;
	level_t            bid_q, ask_q;

	logic         out_vld_q;
	logic [399:0] out_data_q;
	logic [1:0]   out_user_q;

	entry_t            rdata, wdata, upd_e;
	logic              we, re, upd_we;
	logic [ADDR_W-1:0] waddr, upd_addr;

	logic s_acc, load, last_s1, inst_hit, key_hit, touch_op;
	logic [1:0]         st_n, t_side;
	logic signed [63:0] t_price;
	logic [31:0]        t_size;
	logic [63:0]        t_time;
	logic               t_live;
	logic [31:0]        ns;
	level_t             bid_n, ask_n;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign load     = (state_q == S_APPLY) && (!out_vld_q || m_tready);
	assign last_s1  = vld_s1 && (addr_s1 == ADDR_W'(SLOTS - 1));
	assign re       = (state_q == S_SCAN) && (cnt_q < CNT_W'(SLOTS));
	assign inst_hit = rdata.valid && (rdata.instrument == inst_q);
	assign key_hit  = inst_hit && (rdata.order_key == key_q);
	assign touch_op = (op_q == OP_ADD) || (op_q == OP_CANCEL) || (op_q == OP_MODIFY);

	obt_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (cnt_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		upd_we   = 1'b0;
		upd_addr = hit_idx_q;
		upd_e    = hit_e_q;
		st_n     = ST_NONE;
		t_side   = SIDE_NONE;
		t_price  = '0;
		t_size   = '0;
		t_time   = '0;
		t_live   = 1'b0;
		ns       = hit_e_q.size;
		priority if (op_q == OP_ADD) begin
			if (hit_q) begin
				st_n   = ST_ORDER;
				t_live = 1'b1;
			end else if (free_q) begin
				upd_we   = 1'b1;
				upd_addr = free_idx_q;
				upd_e    = '{1'b1, inst_q, key_q, side_q, price_q, qty_q, time_q};
				st_n     = ST_ORDER;
				t_live   = 1'b1;
			end else begin
				st_n = ST_FULL;
			end
		end else if (op_q == OP_CANCEL) begin
			if (hit_q) begin
				if (hit_e_q.size >= qty_q) begin
					ns = hit_e_q.size - qty_q;
				end
				upd_we      = 1'b1;
				upd_e.size  = ns;
				upd_e.valid = (ns != '0) || (hit_e_q.size < qty_q);
				st_n        = ST_ORDER;
				t_live      = upd_e.valid;
			end
		end else if (op_q == OP_MODIFY) begin
			if (hit_q) begin
				if (hit_e_q.price != price_q || hit_e_q.size < qty_q) begin
					upd_e.stamp = time_q;
				end
				upd_e.size  = qty_q;
				upd_e.price = price_q;
				upd_we      = 1'b1;
				st_n        = ST_ORDER;
				t_live      = 1'b1;
			end
		end else begin
			st_n = ST_NONE;
		end
		if (st_n == ST_ORDER) begin
			t_side  = upd_e.side;
			t_price = upd_e.price;
			t_size  = upd_e.size;
			t_time  = upd_e.stamp;
		end
		bid_n = bid_q;
		ask_n = ask_q;
		if (t_live && t_side == SIDE_BUY) begin
			bid_n = level_fold(bid_q, t_price, t_size, 1'b1);
		end
		if (t_live && t_side == SIDE_SELL) begin
			ask_n = level_fold(ask_q, t_price, t_size, 1'b0);
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rdata;
		unique case (state_q)
			S_WIPE: begin
				we    = 1'b1;
				waddr = cnt_q[ADDR_W-1:0];
				wdata = '0;
			end
			S_SCAN: begin
				we          = vld_s1 && (op_q == OP_CLEAR) && inst_hit;
				wdata.valid = 1'b0;
			end
			S_APPLY: begin
				we    = load && upd_we;
				waddr = upd_addr;
				wdata = upd_e;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_WIPE;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= re;
			if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_WIPE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (re) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (last_s1) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (load) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_WIPE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q[ADDR_W-1:0];
		if (s_acc) begin
			op_q    <= s_tuser;
			inst_q  <= s_tdata[31:0];
			key_q   <= s_tdata[95:32];
			side_q  <= (s_tdata[97:96] == SIDE_BAD) ? SIDE_NONE : s_tdata[97:96];
			price_q <= s_tdata[161:98];
			qty_q   <= s_tdata[193:162];
			time_q  <= s_tdata[257:194];
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			bid_q   <= '0;
			ask_q   <= '0;
		end else if (state_q == S_SCAN && vld_s1) begin
			if (key_hit && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= addr_s1;
				hit_e_q   <= rdata;
			end
			if (!rdata.valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= addr_s1;
			end
			if (inst_hit && op_q != OP_CLEAR && !(key_hit && touch_op)) begin
				if (rdata.side == SIDE_BUY) begin
					bid_q <= level_fold(bid_q, rdata.price, rdata.size, 1'b1);
				end
				if (rdata.side == SIDE_SELL) begin
					ask_q <= level_fold(ask_q, rdata.price, rdata.size, 1'b0);
				end
			end
		end
		if (load) begin
			out_user_q <= st_n;
			out_data_q <= {4'b0, ask_n.count, ask_n.size, ask_n.price,
				bid_n.count, bid_n.size, bid_n.price, t_time, t_size, t_price, t_side};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
`default_nettype wire

// ----- hdl/obt_checker.sv -----
`default_nettype none
module obt_checker
	import obt_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [399:0] m_tdata,
	input wire logic [1:0]   m_tuser
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_ORDER || m_tuser == ST_NONE || m_tuser == ST_FULL))
		else $error("bad status");

	a_no_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_ORDER) |-> (m_tdata[161:0] == {160'b0, SIDE_NONE}))
		else $error("order fields without order");

	a_empty_bid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[278:268] == '0) |-> (m_tdata[267:162] == '0))
		else $error("bid fields without bid");

	a_empty_ask: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[395:385] == '0) |-> (m_tdata[384:279] == '0))
		else $error("ask fields without ask");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled transaction dropped");

endmodule

bind order_book_with_top_of_book obt_checker u_obt_checker (.*);
`default_nettype wire
